>>> src/pps_pkg.sv
`default_nettype none
package pps_pkg;

  // Default field widths
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int POSITION_BITS_DEF = 20;

  // Depths of the job queue and the result queue
  localparam int JOB_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  // Job: position, pending score, earlier score, next score, calc, is_peak, record_end
  function automatic int job_width(input int sample_bits, input int position_bits);
    return position_bits + 3 * (sample_bits - 1) + 3;
  endfunction

  // Result: position, score, prominence, weighted score, is_peak, record_end
  function automatic int res_width(input int sample_bits, input int position_bits);
    return position_bits + (sample_bits - 1) + (2 * sample_bits - 1)
           + (3 * sample_bits - 2) + 2;
  endfunction

endpackage
`default_nettype wire

>>> src/pps_fifo.sv
`default_nettype none
module pps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o,
  output logic      [CntW-1:0]  count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> src/pps_front.sv
`default_nettype none
module pps_front #(
  parameter int SAMPLE_BITS   = pps_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS = pps_pkg::POSITION_BITS_DEF,
  localparam int JobW = pps_pkg::job_width(SAMPLE_BITS, POSITION_BITS)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic        [POSITION_BITS-1:0] position_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          last_i,
  output logic                               job_push_o,
  output logic             [JobW-1:0]        job_o,
  input  wire logic                          job_full_i
);
  import pps_pkg::*;

  typedef struct packed {
    logic [POSITION_BITS-1:0] pos;
    logic [SAMPLE_BITS-2:0]   p;
    logic [SAMPLE_BITS-2:0]   e;
    logic [SAMPLE_BITS-2:0]   n;
    logic                     calc;
    logic                     is_peak;
    logic                     rec_end;
  } job_t;

  logic signed [SAMPLE_BITS-1:0]  held_q, held_d;
  logic        [POSITION_BITS-1:0] held_pos_q, held_pos_d;
  logic                           rising_q, rising_d;
  logic                           have_q, have_d;
  logic        [SAMPLE_BITS-2:0]  pend_q, pend_d;
  logic        [POSITION_BITS-1:0] pend_pos_q, pend_pos_d;
  logic        [SAMPLE_BITS-2:0]  earlier_q, earlier_d;
  logic        [1:0]              cnt_q, cnt_d;
  logic                           spill_v_q, spill_v_d;
  job_t                           spill_q, spill_d;

  logic accept, peak_found, a_v, b_v, low_valley;
  job_t job_a, job_b, job_sel;
  logic [SAMPLE_BITS-2:0]   pend_nx, earlier_nx;
  logic [POSITION_BITS-1:0] pend_pos_nx;
  logic [1:0]               cnt_nx;

  assign full   = spill_v_q | job_full_i;
  assign accept = push & ~full;

  assign peak_found = have_q & rising_q & (sample_i < held_q)
                      & ~held_q[SAMPLE_BITS-1] & (|held_q);

  assign low_valley = (pend_q < earlier_q) && (pend_q < held_q[SAMPLE_BITS-2:0]);

  always_comb begin
    // Emit the pending peak once its successor peak is known
    a_v           = peak_found & (cnt_q != 2'd0);
    job_a.pos     = pend_pos_q;
    job_a.p       = pend_q;
    job_a.e       = earlier_q;
    job_a.n       = held_q[SAMPLE_BITS-2:0];
    job_a.calc    = (cnt_q == 2'd2) & ~low_valley;
    job_a.is_peak = 1'b1;
    job_a.rec_end = 1'b0;

    pend_nx     = peak_found ? held_q[SAMPLE_BITS-2:0] : pend_q;
    pend_pos_nx = peak_found ? held_pos_q : pend_pos_q;
    earlier_nx  = (peak_found && cnt_q != 2'd0) ? pend_q : earlier_q;
    cnt_nx      = (peak_found && cnt_q != 2'd2) ? cnt_q + 2'd1 : cnt_q;

    // Close the record: last peak or an empty marker
    b_v           = last_i;
    job_b.is_peak = (cnt_nx != 2'd0);
    job_b.pos     = job_b.is_peak ? pend_pos_nx : '0;
    job_b.p       = job_b.is_peak ? pend_nx : '0;
    job_b.e       = '0;
    job_b.n       = '0;
    job_b.calc    = 1'b0;
    job_b.rec_end = 1'b1;
  end

  always_comb begin
    held_d     = held_q;
    held_pos_d = held_pos_q;
    rising_d   = rising_q;
    have_d     = have_q;
    pend_d     = pend_q;
    pend_pos_d = pend_pos_q;
    earlier_d  = earlier_q;
    cnt_d      = cnt_q;
    spill_v_d  = spill_v_q;
    spill_d    = spill_q;
    job_sel    = job_a;
    job_push_o = 1'b0;

    if (spill_v_q) begin
      job_sel    = spill_q;
      job_push_o = ~job_full_i;
      if (!job_full_i) begin
        spill_v_d = 1'b0;
      end
    end else if (accept) begin
      job_sel    = a_v ? job_a : job_b;
      job_push_o = a_v | b_v;
      if (a_v && b_v) begin
        spill_v_d = 1'b1;
        spill_d   = job_b;
      end
      if (last_i) begin
        held_d     = '0;
        held_pos_d = '0;
        rising_d   = 1'b1;
        have_d     = 1'b0;
        pend_d     = '0;
        pend_pos_d = '0;
        earlier_d  = '0;
        cnt_d      = '0;
      end else begin
        held_d     = sample_i;
        held_pos_d = position_i;
        rising_d   = have_q ? (sample_i >= held_q) : 1'b1;
        have_d     = 1'b1;
        pend_d     = pend_nx;
        pend_pos_d = pend_pos_nx;
        earlier_d  = earlier_nx;
        cnt_d      = cnt_nx;
      end
    end
  end

  assign job_o = job_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      held_pos_q <= '0;
      rising_q   <= 1'b1;
      have_q     <= 1'b0;
      pend_q     <= '0;
      pend_pos_q <= '0;
      earlier_q  <= '0;
      cnt_q      <= '0;
      spill_v_q  <= 1'b0;
    end else begin
      held_q     <= held_d;
      held_pos_q <= held_pos_d;
      rising_q   <= rising_d;
      have_q     <= have_d;
      pend_q     <= pend_d;
      pend_pos_q <= pend_pos_d;
      earlier_q  <= earlier_d;
      cnt_q      <= cnt_d;
      spill_v_q  <= spill_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spill_q <= spill_d;
  end

`ifndef SYNTHESIS
  a_spill_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spill_v_q |-> full)
    else $error("held second job does not block input");
  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("peak count passed saturation");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_i |=> !have_q && cnt_q == 2'd0 && rising_q)
    else $error("record state not cleared after last beat");
`endif

endmodule
`default_nettype wire

>>> src/pps_back.sv
`default_nettype none
module pps_back #(
  parameter int SAMPLE_BITS   = pps_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS = pps_pkg::POSITION_BITS_DEF,
  parameter int RES_DEPTH     = pps_pkg::RES_DEPTH,
  localparam int JobW = pps_pkg::job_width(SAMPLE_BITS, POSITION_BITS),
  localparam int ResW = pps_pkg::res_width(SAMPLE_BITS, POSITION_BITS),
  localparam int CntW = $clog2(RES_DEPTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [JobW-1:0] job_i,
  input  wire logic            job_empty_i,
  output logic                 job_pop_o,
  output logic                 res_push_o,
  output logic      [ResW-1:0] res_o,
  input  wire logic [CntW-1:0] res_count_i,
  input  wire logic            res_full_i
);
  import pps_pkg::*;

  typedef struct packed {
    logic [POSITION_BITS-1:0] pos;
    logic [SAMPLE_BITS-2:0]   p;
    logic [SAMPLE_BITS-2:0]   e;
    logic [SAMPLE_BITS-2:0]   n;
    logic                     calc;
    logic                     is_peak;
    logic                     rec_end;
  } job_t;

  typedef struct packed {
    logic [POSITION_BITS-1:0]   pos;
    logic [SAMPLE_BITS-2:0]     score;
    logic [2*SAMPLE_BITS-2:0]   prom;
    logic [3*SAMPLE_BITS-3:0]   weight;
    logic                       is_peak;
    logic                       rec_end;
  } res_t;

  job_t job;
  logic issue;
  logic [CntW:0] in_use;

  logic signed [SAMPLE_BITS-1:0]   d_e, d_n;
  logic signed [2*SAMPLE_BITS-1:0] prod1;
  logic signed [SAMPLE_BITS-1:0]   score_s;
  logic signed [3*SAMPLE_BITS-2:0] prod2;

  logic                       s1_v_q, s2_v_q;
  job_t                       s1_job_q;
  logic [2*SAMPLE_BITS-2:0]   s1_prom_q;
  res_t                       s2_res_q;

  assign job = job_t'(job_i);

  // Reserve a result slot for every job in flight
  assign in_use = {1'b0, res_count_i} + (CntW + 1)'(s1_v_q) + (CntW + 1)'(s2_v_q);
  assign issue  = ~job_empty_i & (in_use < (CntW + 1)'(RES_DEPTH));
  assign job_pop_o = issue;

  // Stage 1: neighbor differences and their product
  assign d_e   = $signed({1'b0, job.p}) - $signed({1'b0, job.e});
  assign d_n   = $signed({1'b0, job.p}) - $signed({1'b0, job.n});
  assign prod1 = d_e * d_n;

  // Stage 2: score times prominence
  assign score_s = $signed({1'b0, s1_job_q.p});
  assign prod2   = score_s * $signed(s1_prom_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_job_q  <= job;
      s1_prom_q <= job.calc ? prod1[2*SAMPLE_BITS-2:0] : '0;
    end
    if (s1_v_q) begin
      s2_res_q.pos     <= s1_job_q.pos;
      s2_res_q.score   <= s1_job_q.p;
      s2_res_q.prom    <= s1_prom_q;
      s2_res_q.weight  <= prod2[3*SAMPLE_BITS-3:0];
      s2_res_q.is_peak <= s1_job_q.is_peak;
      s2_res_q.rec_end <= s1_job_q.rec_end;
    end
  end

  assign res_push_o = s2_v_q;
  assign res_o      = s2_res_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> !res_full_i)
    else $error("result queue overflow");
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_use <= (CntW + 1)'(RES_DEPTH))
    else $error("more results in flight than slots");
  a_issue_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> s1_v_q ##1 s2_v_q)
    else $error("issued job lost in multiplier pipe");
`endif

endmodule
`default_nettype wire

>>> src/peak_prominence_stream_unit.sv
`default_nettype none
// Streaming local-maximum peak detector with neighbor prominence. Push one
// sample beat per cycle (position, signed sample, last); a sample is a peak
// when it is the first of a record or at least its predecessor, its successor
// is strictly smaller, and it is positive; the last sample never is. Each peak
// comes out once the next peak or the record end is known, with prominence 0
// for the first and last peaks of a record and for an interior peak lower than
// both neighbor peaks, and (p-prev)*(p-next) otherwise, plus score times
// prominence. The final result of a record has record_end set; a record
// without peaks yields one all-zero marker with is_peak low. The front
// classifies one sample per cycle while full is low; a sample that closes a
// record while also resolving a peak produces two results and holds full
// high until the second one has entered the job queue. Results leave a
// four-entry job queue into a two-stage multiplier pipe (difference product,
// then score product), one per cycle while result slots are free, and land
// in a four-entry result queue. There is no clearing pass after reset.
module peak_prominence_stream_unit #(
  parameter int SAMPLE_BITS   = pps_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS = pps_pkg::POSITION_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // sample side
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic        [POSITION_BITS-1:0] position_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   sample_i,
  input  wire logic                            last_i,
  // result side
  output logic                                 empty,
  input  wire logic                            pop,
  output logic             [POSITION_BITS-1:0] peak_position_o,
  output logic             [SAMPLE_BITS-2:0]   peak_score_o,
  output logic signed      [2*SAMPLE_BITS-2:0] prominence_o,
  output logic signed      [3*SAMPLE_BITS-3:0] weighted_score_o,
  output logic                                 is_peak_o,
  output logic                                 record_end_o
);
  import pps_pkg::*;

  localparam int JobW    = job_width(SAMPLE_BITS, POSITION_BITS);
  localparam int ResW    = res_width(SAMPLE_BITS, POSITION_BITS);
  localparam int JobCntW = $clog2(JOB_DEPTH + 1);
  localparam int ResCntW = $clog2(RES_DEPTH + 1);

  typedef struct packed {
    logic [POSITION_BITS-1:0]   pos;
    logic [SAMPLE_BITS-2:0]     score;
    logic [2*SAMPLE_BITS-2:0]   prom;
    logic [3*SAMPLE_BITS-3:0]   weight;
    logic                       is_peak;
    logic                       rec_end;
  } res_t;

  logic              job_push, job_pop, job_full, job_empty;
  logic [JobW-1:0]   job_wdata, job_rdata;
  logic [JobCntW-1:0] job_count;

  logic              res_push, res_full;
  logic [ResW-1:0]   res_wdata, res_rdata;
  logic [ResCntW-1:0] res_count;
  res_t              res;

  // Classify samples, track pending and earlier peaks
  pps_front #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .position_i (position_i),
    .sample_i   (sample_i),
    .last_i     (last_i),
    .job_push_o (job_push),
    .job_o      (job_wdata),
    .job_full_i (job_full)
  );

  // Decouple classification from the multiplier pipe
  pps_fifo #(
    .WIDTH(JobW),
    .DEPTH(JOB_DEPTH)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_wdata),
    .pop_i  (job_pop),
    .data_o (job_rdata),
    .full_o (job_full),
    .empty_o(job_empty),
    .count_o(job_count)
  );

  // Compute prominence and weighted score
  pps_back #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .POSITION_BITS(POSITION_BITS),
    .RES_DEPTH    (RES_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job_rdata),
    .job_empty_i(job_empty),
    .job_pop_o  (job_pop),
    .res_push_o (res_push),
    .res_o      (res_wdata),
    .res_count_i(res_count),
    .res_full_i (res_full)
  );

  // Hold finished results until the consumer pops them
  pps_fifo #(
    .WIDTH(ResW),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_wdata),
    .pop_i  (pop),
    .data_o (res_rdata),
    .full_o (res_full),
    .empty_o(empty),
    .count_o(res_count)
  );

  assign res              = res_t'(res_rdata);
  assign peak_position_o  = res.pos;
  assign peak_score_o     = res.score;
  assign prominence_o     = $signed(res.prom);
  assign weighted_score_o = $signed(res.weight);
  assign is_peak_o        = res.is_peak;
  assign record_end_o     = res.rec_end;

`ifndef SYNTHESIS
  a_job_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("job queue overflow");
  a_job_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_empty == (job_count == '0))
    else $error("job queue count and empty flag disagree");
`endif

endmodule
`default_nettype wire
